>>> sv/fem_pkg.sv
// Package for the fault escalation manager: item structs, operation and severity
// codes, register indexes and reset values, and the tick scan summary struct.
// No dependencies.
`timescale 1ns / 1ps

package fem_pkg;

  typedef enum logic [1:0] {
    OP_TRIGGER = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    SEV_CRITICAL    = 2'd0,
    SEV_RECOVERABLE = 2'd1,
    SEV_WARNING     = 2'd2,
    SEV_PLAIN       = 2'd3
  } sev_e;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SEVERITY_MAP = 2'd0;
  localparam logic [1:0] REG_RECOVER_TIME = 2'd1;
  localparam logic [1:0] REG_TOGGLE_PERIOD = 2'd2;

  localparam logic [15:0] SEVERITY_MAP_RST  = 16'hA440;
  localparam logic [31:0] RECOVER_TIME_RST  = 32'd10000;
  localparam logic [15:0] TOGGLE_PERIOD_RST = 16'd500;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  error_index;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic       red_led;
    logic       green_led;
    logic       halted;
    logic [2:0] halt_source;
  } out_item_t;

  // Summary of one tick scan over the source table
  typedef struct packed {
    logic       halt;
    logic [2:0] halt_idx;
    logic       restart_timer;
    logic       toggle_red;
    logic       toggle_green;
  } scan_t;

endpackage

>>> sv/fem_if.sv
// Valid/ready channel interfaces for the fault escalation manager items.
// Depends on fem_pkg for the payload structs.
`timescale 1ns / 1ps

interface fem_in_if;
  logic             valid;
  logic             ready;
  fem_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fem_out_if;
  logic              valid;
  logic              ready;
  fem_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/fem_tick_scan.sv
// Tick scan of the source table: escalation search and indicator toggle decision.
// Depends on fem_pkg.
`timescale 1ns / 1ps

module fem_tick_scan #(
  parameter int NUM_SOURCES = 8
) (
  input  logic [NUM_SOURCES-1:0] active_i,
  input  logic [31:0]            stamp_i [NUM_SOURCES],
  input  logic [15:0]            severity_map_i,
  input  logic [31:0]            recover_time_i,
  input  logic [15:0]            toggle_period_i,
  input  logic [31:0]            clock_i,
  input  logic [31:0]            last_toggle_i,
  output fem_pkg::scan_t         scan_o
);

  logic [NUM_SOURCES-1:0] expired;
  logic                   period_zero;
  logic                   period_pass;

  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      expired[i] = ((clock_i - stamp_i[i]) >= recover_time_i);
    end
  end

  assign period_zero = (toggle_period_i == 16'd0);
  assign period_pass = ((clock_i - last_toggle_i) >= {16'd0, toggle_period_i});

  // Walk the sources in index order; active sources ahead of the first escalating
  // source drive the toggles: all of them if the period is zero, else the first.
  always_comb begin
    logic          found;
    logic          seen;
    logic          red_par;
    logic          green_par;
    logic [2:0]    hidx;
    fem_pkg::sev_e sev;
    found     = 1'b0;
    seen      = 1'b0;
    red_par   = 1'b0;
    green_par = 1'b0;
    hidx      = 3'd0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      sev = fem_pkg::sev_e'(severity_map_i[2*i +: 2]);
      if (active_i[i] && !found) begin
        if (sev == fem_pkg::SEV_RECOVERABLE && expired[i]) begin
          found = 1'b1;
          hidx  = 3'(i);
        end else begin
          if (period_zero || !seen) begin
            red_par   = red_par ^ (sev == fem_pkg::SEV_RECOVERABLE);
            green_par = green_par ^ (sev == fem_pkg::SEV_WARNING);
          end
          seen = 1'b1;
        end
      end
    end
    scan_o.halt          = found;
    scan_o.halt_idx      = hidx;
    scan_o.restart_timer = seen && period_pass;
    scan_o.toggle_red    = red_par && period_pass;
    scan_o.toggle_green  = green_par && period_pass;
  end

endmodule

>>> sv/fault_escalation_manager.sv
// Fault escalation manager: result valid in the cycle after the input transfer;
// 1 item per cycle while the result register is empty or draining, one result per
// item, set by the table update and the tick scan's 32-bit elapsed-time compares.
// Reset (rst_ni low, asynchronous): source table, clock, indicators and halt clear;
// registers return to their default values. No clearing pass is needed.
// Depends on fem_pkg, fem_if (fem_in_if, fem_out_if) and fem_tick_scan.
`timescale 1ns / 1ps

module fault_escalation_manager #(
  parameter int NUM_SOURCES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fem_in_if.sink      in_i,
  fem_out_if.source   out_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] sev_map_q;
  logic [31:0] recover_q;
  logic [15:0] period_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sev_map_q <= fem_pkg::SEVERITY_MAP_RST;
      recover_q <= fem_pkg::RECOVER_TIME_RST;
      period_q  <= fem_pkg::TOGGLE_PERIOD_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        fem_pkg::REG_SEVERITY_MAP:  sev_map_q <= pwdata[15:0];
        fem_pkg::REG_RECOVER_TIME:  recover_q <= pwdata;
        fem_pkg::REG_TOGGLE_PERIOD: period_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fem_pkg::REG_SEVERITY_MAP:  prdata = {16'd0, sev_map_q};
      fem_pkg::REG_RECOVER_TIME:  prdata = recover_q;
      fem_pkg::REG_TOGGLE_PERIOD: prdata = {16'd0, period_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register frees up when its transfer completes, so
  // take a new item whenever the register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  fem_pkg::out_item_t out_data_q;
  logic               in_fire;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------------------------------------------------------------------
  // Source table and global state
  // ---------------------------------------------------------------------------
  logic [NUM_SOURCES-1:0] active_q, active_d;
  logic [NUM_SOURCES-1:0] timeout_q, timeout_d;
  logic [31:0]            stamp_q [NUM_SOURCES];
  logic [31:0]            stamp_d [NUM_SOURCES];
  logic [31:0]            clock_q, clock_d;
  logic [31:0]            last_toggle_q, last_toggle_d;
  logic                   red_q, red_d;
  logic                   green_q, green_d;
  logic                   halt_q, halt_d;
  logic [2:0]             halt_idx_q, halt_idx_d;

  logic [31:0]            tick_clock;
  fem_pkg::scan_t         scan;

  // Clock value after this tick; the scan measures ages against it
  assign tick_clock = clock_q + {16'd0, in_i.data.elapsed_ms};

  fem_tick_scan #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_scan (
    .active_i       (active_q),
    .stamp_i        (stamp_q),
    .severity_map_i (sev_map_q),
    .recover_time_i (recover_q),
    .toggle_period_i(period_q),
    .clock_i        (tick_clock),
    .last_toggle_i  (last_toggle_q),
    .scan_o         (scan)
  );

  always_comb begin
    logic [NUM_SOURCES-1:0] sel;
    logic                   sel_halt;
    sel_halt      = 1'b0;
    active_d      = active_q;
    timeout_d     = timeout_q;
    stamp_d       = stamp_q;
    clock_d       = clock_q;
    last_toggle_d = last_toggle_q;
    red_d         = red_q;
    green_d       = green_q;
    halt_d        = halt_q;
    halt_idx_d    = halt_idx_q;

    // One-hot source select; indices beyond the table select nothing
    for (int i = 0; i < NUM_SOURCES; i++) begin
      sel[i] = (in_i.data.error_index == 4'(i));
    end

    if (!halt_q) begin
      case (in_i.data.operation)
        fem_pkg::OP_TRIGGER: begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (sel[i]) begin
              // Stamp only on the inactive-to-active edge
              if (!active_q[i]) begin
                active_d[i] = 1'b1;
                stamp_d[i]  = clock_q;
              end
              if (fem_pkg::sev_e'(sev_map_q[2*i +: 2]) == fem_pkg::SEV_CRITICAL ||
                  timeout_q[i]) begin
                sel_halt   = 1'b1;
                halt_idx_d = 3'(i);
              end
            end
          end
          if (sel_halt) begin
            halt_d = 1'b1;
            red_d  = 1'b1;
          end
        end
        fem_pkg::OP_CLEAR: begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (sel[i] && active_q[i]) begin
              active_d[i]  = 1'b0;
              timeout_d[i] = 1'b0;
              stamp_d[i]   = 32'd0;
              red_d        = 1'b0;
            end
          end
        end
        fem_pkg::OP_TICK: begin
          clock_d = tick_clock;
          if (scan.restart_timer) begin
            last_toggle_d = tick_clock;
          end
          red_d   = red_q ^ scan.toggle_red;
          green_d = green_q ^ scan.toggle_green;
          // Escalation ends the scan; toggles ahead of it still stand
          if (scan.halt) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
              if (scan.halt_idx == 3'(i)) begin
                timeout_d[i] = 1'b1;
              end
            end
            halt_d     = 1'b1;
            halt_idx_d = scan.halt_idx;
            red_d      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= '0;
      timeout_q     <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        stamp_q[i] <= 32'd0;
      end
      clock_q       <= 32'd0;
      last_toggle_q <= 32'd0;
      red_q         <= 1'b0;
      green_q       <= 1'b0;
      halt_q        <= 1'b0;
      halt_idx_q    <= 3'd0;
    end else if (in_fire) begin
      active_q      <= active_d;
      timeout_q     <= timeout_d;
      stamp_q       <= stamp_d;
      clock_q       <= clock_d;
      last_toggle_q <= last_toggle_d;
      red_q         <= red_d;
      green_q       <= green_d;
      halt_q        <= halt_d;
      halt_idx_q    <= halt_idx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load the post-item view on each accepted transfer,
  // drop valid once the result transfer completes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.red_led     <= halt_d || red_d;
      out_data_q.green_led   <= green_d;
      out_data_q.halted      <= halt_d;
      out_data_q.halt_source <= halt_d ? halt_idx_d : 3'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Halt is sticky and freezes the clock and the halting index
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> (halt_q && $stable(clock_q) && $stable(halt_idx_q)))
    else $error("halt state changed after halt");

  // A halted result always shows the red indicator on
  a_halt_red : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.halted) |-> out_data_q.red_led)
    else $error("halted result without red indicator");

  // A result appears only after an input transfer
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire))
    else $error("result valid without an accepted item");

  // The state only moves on an accepted item
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(clock_q) && $stable(active_q) && $stable(halt_q)))
    else $error("state changed without an accepted item");

endmodule
